[rtl/bbcp_pkg.sv]
// Shared definitions for the block buffer cache policy engine.
// Opcodes, port field widths, default sizes and the controller/datapath link types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbcp_pkg;

  localparam int DEF_NUM_BUFFERS = 5;
  localparam int DEF_MAX_BLOCKS  = 1024;

  localparam int OPC_W  = 3;
  localparam int BLK_W  = 10;
  localparam int SLOT_W = 3;

  typedef enum logic [OPC_W-1:0] {
    OP_LOOKUP = 3'd0,
    OP_MARK   = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_FORGET = 3'd4,
    OP_FLUSH  = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the incoming beat
    logic renum;  // insert renumbering step
    logic exec;   // main step: update state and register the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_insert;  // incoming beat is an insert
  } stat_t;

endpackage

`default_nettype wire

[rtl/bbcp_ctrl.sv]
// Sequencer for the block buffer cache policy engine.
// Depends on bbcp_pkg; drives the datapath through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module bbcp_ctrl import bbcp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire stat_t st,
  output logic       busy,
  output logic       done,
  output cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RENUM,
    S_EXEC
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd.load  = (state == S_IDLE) && start;
    cmd.renum = (state == S_RENUM);
    cmd.exec  = (state == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_EXEC);
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= st.req_insert ? S_RENUM : S_EXEC;
          end
        end
        S_RENUM: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/bbcp_dpath.sv]
// Slot register file, match/victim logic and result registers.
// Depends on bbcp_pkg; steered by bbcp_ctrl through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module bbcp_dpath import bbcp_pkg::*; #(
  parameter int NUM_BUFFERS = DEF_NUM_BUFFERS,
  parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output stat_t                  st,
  input  wire logic [OPC_W-1:0]  opcode,
  input  wire logic [BLK_W-1:0]  block_number,
  input  wire logic [SLOT_W-1:0] slot_index,
  output logic [SLOT_W-1:0]      slot,
  output logic                   hit,
  output logic                   is_header,
  output logic                   evict_valid,
  output logic [BLK_W-1:0]       evict_block,
  output logic                   evict_dirty,
  output logic [BLK_W-1:0]       entry_block,
  output logic                   entry_dirty
);

  localparam int IW = $clog2(NUM_BUFFERS);      // slot index
  localparam int SW = $clog2(NUM_BUFFERS + 1);  // slot index plus "none"
  localparam int BW = $clog2(MAX_BLOCKS);       // stored block number
  localparam logic [SW-1:0] NONE  = SW'(NUM_BUFFERS);
  localparam logic [BW:0]   LIMIT = (BW+1)'(MAX_BLOCKS);

  // captured beat
  logic [OPC_W-1:0]  op_q;
  logic [BLK_W-1:0]  blk_q;
  logic [SLOT_W-1:0] si_q;

  // policy state
  logic [BW-1:0]          slot_block [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] slot_dirty;
  logic [SW-1:0]          most_recent;
  logic [SW-1:0]          second_recent;
  logic [IW-1:0]          victim_pointer;

  logic [BW-1:0]          slot_block_next [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] slot_dirty_next;
  logic [SW-1:0]          most_recent_next;
  logic [SW-1:0]          second_recent_next;
  logic [IW-1:0]          victim_pointer_next;

  logic [SLOT_W-1:0] slot_next;
  logic              hit_next;
  logic              is_header_next;
  logic              evict_valid_next;
  logic [BLK_W-1:0]  evict_block_next;
  logic              evict_dirty_next;
  logic [BLK_W-1:0]  entry_block_next;
  logic              entry_dirty_next;

  logic [BW+BLK_W-1:0]  blk_ext;
  logic [BW-1:0]        blk_b;
  logic                 blk_ok;
  logic [IW+SLOT_W-1:0] si_ext;
  logic [IW-1:0]        si_i;
  logic                 si_ok;
  logic                 is_lookup;
  logic [NUM_BUFFERS-1:0] match;
  logic                 hit_any;
  logic [IW-1:0]        hit_idx;
  logic [IW-1:0]        cand0, cand1, cand2, victim;
  logic [IW-1:0]        ridx;
  logic                 rd_ok;
  logic [BW-1:0]        rd_blk;
  logic                 rd_dirty;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] c);
    if (c == IW'(NUM_BUFFERS - 1)) begin
      return '0;
    end
    return c + IW'(1);
  endfunction

  function automatic logic excluded(input logic [IW-1:0] c, input logic [SW-1:0] a,
                                    input logic [SW-1:0] b);
    return (SW'(c) == a) || (SW'(c) == b);
  endfunction

  function automatic logic [BLK_W-1:0] blk_port(input logic [BW-1:0] x);
    logic [BW+BLK_W-1:0] t;
    t = {{BLK_W{1'b0}}, x};
    return t[BLK_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_port(input logic [IW-1:0] x);
    logic [IW+SLOT_W-1:0] t;
    t = {{SLOT_W{1'b0}}, x};
    return t[SLOT_W-1:0];
  endfunction

  assign st.req_insert = (opcode == OP_INSERT);

  assign blk_ext = {{BW{1'b0}}, blk_q};
  assign blk_b   = blk_ext[BW-1:0];
  assign blk_ok  = (blk_q != '0) && (32'(blk_q) < MAX_BLOCKS);
  assign si_ext  = {{IW{1'b0}}, si_q};
  assign si_i    = si_ext[IW-1:0];
  assign si_ok   = (32'(si_q) < NUM_BUFFERS);
  assign is_lookup = (op_q == OP_LOOKUP) || (op_q == OP_INSERT);

  // tag compare across all slots, lowest matching slot wins
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      match[i] = (slot_block[i] == blk_b);
    end
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IW'(i);
      end
    end
  end
  assign hit_any = blk_ok && (|match);

  // round robin; only two slots are ever skipped, so three candidates suffice
  assign cand0  = victim_pointer;
  assign cand1  = wrap_inc(cand0);
  assign cand2  = wrap_inc(cand1);
  assign victim = !excluded(cand0, most_recent, second_recent) ? cand0 :
                  !excluded(cand1, most_recent, second_recent) ? cand1 : cand2;

  assign ridx     = is_lookup ? (hit_any ? hit_idx : victim) : si_i;
  assign rd_ok    = is_lookup || si_ok;
  assign rd_blk   = rd_ok ? slot_block[ridx] : '0;
  assign rd_dirty = rd_ok ? slot_dirty[ridx] : 1'b0;

  always_comb begin
    slot_block_next     = slot_block;
    slot_dirty_next     = slot_dirty;
    most_recent_next    = most_recent;
    second_recent_next  = second_recent;
    victim_pointer_next = victim_pointer;
    slot_next        = '0;
    hit_next         = 1'b0;
    is_header_next   = 1'b0;
    evict_valid_next = 1'b0;
    evict_block_next = '0;
    evict_dirty_next = 1'b0;
    entry_block_next = '0;
    entry_dirty_next = 1'b0;

    if (cmd.renum) begin
      // insert: shift every block at or above the new number up by one; a block pushed to the limit is emptied
      if (blk_ok) begin
        for (int i = 0; i < NUM_BUFFERS; i++) begin
          if ((slot_block[i] != '0) && (slot_block[i] >= blk_b)) begin
            if (({1'b0, slot_block[i]} + (BW+1)'(1)) >= LIMIT) begin
              slot_block_next[i] = '0;
              slot_dirty_next[i] = 1'b0;
            end else begin
              slot_block_next[i] = slot_block[i] + BW'(1);
            end
          end
        end
      end
    end else if (cmd.exec) begin
      if (is_lookup) begin
        if (!blk_ok) begin
          is_header_next = 1'b1;
        end else if (hit_any) begin
          slot_next          = slot_port(hit_idx);
          hit_next           = 1'b1;
          entry_block_next   = blk_q;
          entry_dirty_next   = rd_dirty;
          most_recent_next   = SW'(hit_idx);
          second_recent_next = most_recent;
        end else begin
          slot_next                = slot_port(victim);
          evict_valid_next         = (rd_blk != '0);
          evict_block_next         = blk_port(rd_blk);
          evict_dirty_next         = rd_dirty;
          entry_block_next         = blk_port(rd_blk);
          entry_dirty_next         = rd_dirty;
          slot_block_next[victim]  = blk_b;
          slot_dirty_next[victim]  = 1'b0;
          most_recent_next         = SW'(victim);
          second_recent_next       = most_recent;
          victim_pointer_next      = wrap_inc(victim);
        end
      end else begin
        slot_next = si_q;
        if (si_ok) begin
          entry_block_next = blk_port(rd_blk);
          entry_dirty_next = rd_dirty;
          case (op_q)
            OP_MARK: begin
              if (rd_blk != '0) begin
                slot_dirty_next[si_i] = 1'b1;
              end
            end
            OP_DELETE: begin
              if (rd_blk != '0) begin
                for (int i = 0; i < NUM_BUFFERS; i++) begin
                  if (slot_block[i] >= rd_blk) begin
                    slot_block_next[i] = slot_block[i] - BW'(1);
                  end
                end
                slot_block_next[si_i] = '0;
                slot_dirty_next[si_i] = 1'b0;
              end
            end
            OP_FORGET: begin
              slot_block_next[si_i] = '0;
              slot_dirty_next[si_i] = 1'b0;
            end
            OP_FLUSH: begin
              slot_dirty_next[si_i] = 1'b0;
            end
            OP_CLEAR: begin
              for (int i = 0; i < NUM_BUFFERS; i++) begin
                slot_block_next[i] = '0;
              end
              slot_dirty_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        slot_block[i] <= '0;
      end
      slot_dirty     <= '0;
      most_recent    <= NONE;
      second_recent  <= NONE;
      victim_pointer <= '0;
    end else if (cmd.renum || cmd.exec) begin
      slot_block     <= slot_block_next;
      slot_dirty     <= slot_dirty_next;
      most_recent    <= most_recent_next;
      second_recent  <= second_recent_next;
      victim_pointer <= victim_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      blk_q <= block_number;
      si_q  <= slot_index;
    end
    if (cmd.exec) begin
      slot        <= slot_next;
      hit         <= hit_next;
      is_header   <= is_header_next;
      evict_valid <= evict_valid_next;
      evict_block <= evict_block_next;
      evict_dirty <= evict_dirty_next;
      entry_block <= entry_block_next;
      entry_dirty <= entry_dirty_next;
    end
  end

endmodule

`default_nettype wire

[rtl/block_buffer_cache_policy.sv]
// Top level of the block buffer cache policy engine.
// Depends on bbcp_pkg, bbcp_ctrl and bbcp_dpath.
`timescale 1ns / 1ps
`default_nettype none

// A command beat is taken on a clock edge with start high and busy low. Its
// result appears on the result ports for exactly one cycle with done high;
// there is no back-pressure, so capture it in that cycle. Every opcode runs
// an execute step before its done cycle; insert first renumbers the slot file
// in a step of its own, then runs the lookup on the renumbered slots. busy
// drops in the done cycle, so a new beat can be taken there; no new beat is
// taken while the previous one is still in the controller's load/execute
// sequence over the shared slot register file. All slots reset to empty and
// clean, the recency marks to none and the round robin pointer to slot 0.
module block_buffer_cache_policy import bbcp_pkg::*; #(
  parameter int NUM_BUFFERS = DEF_NUM_BUFFERS,
  parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [OPC_W-1:0]  opcode,
  input  wire logic [BLK_W-1:0]  block_number,
  input  wire logic [SLOT_W-1:0] slot_index,
  output logic                   done,
  output logic [SLOT_W-1:0]      slot,
  output logic                   hit,
  output logic                   is_header,
  output logic                   evict_valid,
  output logic [BLK_W-1:0]       evict_block,
  output logic                   evict_dirty,
  output logic [BLK_W-1:0]       entry_block,
  output logic                   entry_dirty
);

  cmd_t  cmd;  // sequencing from the controller
  stat_t st;   // decode of the incoming beat

  bbcp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // slot file, tag match, victim choice and result registers
  bbcp_dpath #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .opcode       (opcode),
    .block_number (block_number),
    .slot_index   (slot_index),
    .slot         (slot),
    .hit          (hit),
    .is_header    (is_header),
    .evict_valid  (evict_valid),
    .evict_block  (evict_block),
    .evict_dirty  (evict_dirty),
    .entry_block  (entry_block),
    .entry_dirty  (entry_dirty)
  );

endmodule

`default_nettype wire

[rtl/bbcp_check.sv]
// Port-level checks for block_buffer_cache_policy, attached by bind.
// Depends on bbcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbcp_check import bbcp_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire logic [SLOT_W-1:0] slot,
  input wire logic              hit,
  input wire logic              is_header,
  input wire logic              evict_valid,
  input wire logic              evict_dirty
);

  // an accepted beat always occupies the engine for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // the result beat comes once the engine is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // header requests report slot 0 and never evict
  a_header: assert property (@(posedge clk) disable iff (rst)
    (done && is_header) |-> ((slot == '0) && !hit && !evict_valid))
    else $error("header result malformed");

  // a hit never evicts anything
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (!evict_valid && !evict_dirty))
    else $error("hit reported an eviction");

endmodule

bind block_buffer_cache_policy bbcp_check u_bbcp_check (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .slot        (slot),
  .hit         (hit),
  .is_header   (is_header),
  .evict_valid (evict_valid),
  .evict_dirty (evict_dirty)
);

`default_nettype wire

[tb/sv/bbcp_tb_pkg.sv]
// Scoreboard for the block buffer cache policy engine: a shadow of the slot file
// that predicts one reply per command beat and checks the replies in order.
// Depends on bbcp_pkg.
`timescale 1ns / 1ps

package bbcp_tb_pkg;
  import bbcp_pkg::*;

  localparam int SLOTS       = DEF_NUM_BUFFERS;
  localparam int BLOCK_LIMIT = DEF_MAX_BLOCKS;

  // opcode with no defined meaning; reports like a flush, changes nothing
  localparam logic [OPC_W-1:0] OP_RESERVED = 3'd7;

  // same field order as the concatenation of the reply ports
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              is_header;
    logic              evict_valid;
    logic [BLK_W-1:0]  evict_block;
    logic              evict_dirty;
    logic [BLK_W-1:0]  entry_block;
    logic              entry_dirty;
  } cache_reply_t;

  class cache_tag_shadow;
    bit [BLK_W-1:0]  blk_of[SLOTS];
    bit              dirty_of[SLOTS];
    bit [SLOT_W-1:0] mru;
    bit [SLOT_W-1:0] mru2;
    bit [SLOT_W-1:0] rr_ptr;
    cache_reply_t    pending_replies[$];
    int unsigned     mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        blk_of[i]   = '0;
        dirty_of[i] = 1'b0;
      end
      mru         = SLOT_W'(SLOTS);
      mru2        = SLOT_W'(SLOTS);
      rr_ptr      = '0;
      mismatches  = 0;
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    function void touch_slot(bit [SLOT_W-1:0] s);
      mru2 = mru;
      mru  = s;
    endfunction

    // hit refreshes recency; miss takes the next round robin slot that is
    // neither of the two most recent, then loads the block clean
    function cache_reply_t lookup_block(bit [BLK_W-1:0] b);
      cache_reply_t r;
      bit [SLOT_W-1:0] s;
      r = '0;
      if (b == 0 || int'(b) >= BLOCK_LIMIT) begin
        r.is_header = 1'b1;
        return r;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (blk_of[i] == b) begin
          r.slot        = SLOT_W'(i);
          r.hit         = 1'b1;
          r.entry_block = b;
          r.entry_dirty = dirty_of[i];
          touch_slot(SLOT_W'(i));
          return r;
        end
      end
      s = '0;
      for (int n = 0; n < SLOTS + 3; n++) begin
        s      = rr_ptr;
        rr_ptr = (int'(rr_ptr) + 1 >= SLOTS) ? '0 : rr_ptr + 1'b1;
        if (s != mru && s != mru2) break;
      end
      r.slot        = s;
      r.evict_valid = (blk_of[s] != 0);
      r.evict_block = blk_of[s];
      r.evict_dirty = dirty_of[s];
      r.entry_block = blk_of[s];
      r.entry_dirty = dirty_of[s];
      blk_of[s]     = b;
      dirty_of[s]   = 1'b0;
      touch_slot(s);
      return r;
    endfunction

    function void note_command(logic [OPC_W-1:0] op, logic [BLK_W-1:0] bn,
                               logic [SLOT_W-1:0] si);
      cache_reply_t r;
      bit [BLK_W-1:0] k;
      r = '0;
      case (op)
        OP_LOOKUP: r = lookup_block(bn);
        OP_INSERT: begin
          if (bn != 0 && int'(bn) < BLOCK_LIMIT) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (blk_of[i] != 0 && blk_of[i] >= bn) begin
                if (int'(blk_of[i]) + 1 >= BLOCK_LIMIT) begin
                  blk_of[i]   = '0;
                  dirty_of[i] = 1'b0;
                end else begin
                  blk_of[i] = blk_of[i] + 1'b1;
                end
              end
            end
          end
          r = lookup_block(bn);
        end
        default: begin
          r.slot = si;
          if (int'(si) < SLOTS) begin
            r.entry_block = blk_of[si];
            r.entry_dirty = dirty_of[si];
            case (op)
              OP_MARK: if (blk_of[si] != 0) dirty_of[si] = 1'b1;
              OP_DELETE: begin
                k = blk_of[si];
                if (k != 0) begin
                  for (int i = 0; i < SLOTS; i++)
                    if (blk_of[i] >= k) blk_of[i] = blk_of[i] - 1'b1;
                  blk_of[si]   = '0;
                  dirty_of[si] = 1'b0;
                end
              end
              OP_FORGET: begin
                blk_of[si]   = '0;
                dirty_of[si] = 1'b0;
              end
              OP_FLUSH: dirty_of[si] = 1'b0;
              OP_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                  blk_of[i]   = '0;
                  dirty_of[i] = 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
      endcase
      pending_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [BLK_W-1:0] want, logic [BLK_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(cache_reply_t got);
      cache_reply_t want;
      if (pending_replies.size() == 0) begin
        $error("reply with no command outstanding: slot %0d", got.slot);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      compare_field("slot",        BLK_W'(want.slot),        BLK_W'(got.slot));
      compare_field("hit",         BLK_W'(want.hit),         BLK_W'(got.hit));
      compare_field("is_header",   BLK_W'(want.is_header),   BLK_W'(got.is_header));
      compare_field("evict_valid", BLK_W'(want.evict_valid), BLK_W'(got.evict_valid));
      compare_field("evict_block", want.evict_block,         got.evict_block);
      compare_field("evict_dirty", BLK_W'(want.evict_dirty), BLK_W'(got.evict_dirty));
      compare_field("entry_block", want.entry_block,         got.entry_block);
      compare_field("entry_dirty", BLK_W'(want.entry_dirty), BLK_W'(got.entry_dirty));
    endfunction
  endclass

endpackage

[tb/sv/tb_top.sv]
// Top of the block buffer cache policy testbench: clock, reset, command driver,
// reply monitor and watchdog. Depends on bbcp_pkg, bbcp_tb_pkg and the block itself.
`timescale 1ns / 1ps

module tb_top;
  import bbcp_pkg::*;
  import bbcp_tb_pkg::*;

  // longest idle run the driver inserts between beats
  localparam int MAX_GAP        = 16;
  // cycles with neither a command nor a reply beat before giving up;
  // worst case is a full idle run plus an insert's renumber and execute steps
  localparam int WATCHDOG_LIMIT = 200;
  // quiet cycles after the last reply, to catch stray done pulses
  localparam int DRAIN_CYCLES   = 6;
  localparam int RANDOM_BEATS   = 500;  // per idling phase, three phases

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [OPC_W-1:0]  opcode = OP_LOOKUP;
  logic [BLK_W-1:0]  block_number = '0;
  logic [SLOT_W-1:0] slot_index = '0;

  logic              busy;
  logic              done;
  logic [SLOT_W-1:0] slot;
  logic              hit;
  logic              is_header;
  logic              evict_valid;
  logic [BLK_W-1:0]  evict_block;
  logic              evict_dirty;
  logic [BLK_W-1:0]  entry_block;
  logic              entry_dirty;

  cache_tag_shadow sb;
  int unsigned     idle_pct = 0;
  int unsigned     quiet_cycles = 0;

  block_buffer_cache_policy #(
    .NUM_BUFFERS (DEF_NUM_BUFFERS),
    .MAX_BLOCKS  (DEF_MAX_BLOCKS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .block_number (block_number),
    .slot_index   (slot_index),
    .done         (done),
    .slot         (slot),
    .hit          (hit),
    .is_header    (is_header),
    .evict_valid  (evict_valid),
    .evict_block  (evict_block),
    .evict_dirty  (evict_dirty),
    .entry_block  (entry_block),
    .entry_dirty  (entry_dirty)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Monitor. Everything is sampled at the rising edge, before the block's
  // registers update, so a command beat is one where start was high and busy
  // low in the cycle just ending, and a reply beat is one with done high.
  // The reply is checked first: it always belongs to an earlier command, since
  // a command passes the execute state before its done, while the command seen
  // at this edge may be taken in the same cycle that busy drops.
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        sb.check_reply({slot, hit, is_header, evict_valid, evict_block, evict_dirty,
                        entry_block, entry_dirty});
      if (start && !busy)
        sb.note_command(opcode, block_number, slot_index);
      // watchdog: any beat in either direction counts as progress
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("FAIL block_buffer_cache_policy");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // One command beat. An optional idle run comes first (start low); start is
  // only lowered when such a run is taken, so back-to-back beats keep it high.
  // Returns at the edge that accepts the beat.
  task automatic send_command(input logic [OPC_W-1:0] op, input logic [BLK_W-1:0] bn,
                              input logic [SLOT_W-1:0] si);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    opcode       <= op;
    block_number <= bn;
    slot_index   <= si;
    do @(posedge clk); while (busy);
  endtask

  // Random beat. Block numbers mostly come from a dozen small values so that
  // lookups hit, victims get evicted and deletes/inserts collide with live
  // slots; a slice sits near the top of the range to exercise overflow on
  // insert, and the rest is header requests and noise over the full range.
  task automatic send_random_command();
    logic [OPC_W-1:0]  op;
    logic [BLK_W-1:0]  bn;
    logic [SLOT_W-1:0] si;
    int unsigned       pick;
    pick = $urandom_range(99);
    if      (pick < 50) op = OP_LOOKUP;
    else if (pick < 60) op = OP_MARK;
    else if (pick < 68) op = OP_INSERT;
    else if (pick < 76) op = OP_DELETE;
    else if (pick < 82) op = OP_FORGET;
    else if (pick < 90) op = OP_FLUSH;
    else if (pick < 93) op = OP_CLEAR;
    else if (pick < 95) op = OP_RESERVED;
    else                op = OP_LOOKUP;
    pick = $urandom_range(99);
    if      (pick < 70) bn = BLK_W'($urandom_range(12, 1));
    else if (pick < 80) bn = BLK_W'($urandom_range(1023, 1014));
    else if (pick < 85) bn = '0;
    else                bn = BLK_W'($urandom_range(1023, 0));
    // mostly real slots; now and then an index past the end
    if ($urandom_range(99) < 88) si = SLOT_W'($urandom_range(SLOTS - 1, 0));
    else                          si = SLOT_W'($urandom_range(7, SLOTS));
    send_command(op, bn, si);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed beats, no idling. Fill the slots, hit, mark, evict a dirty
    // victim, then walk through the corner cases.
    send_command(OP_LOOKUP,   10'd0,    3'd0);  // header request
    send_command(OP_LOOKUP,   10'd1023, 3'd7);  // top block, miss into empty slot
    send_command(OP_LOOKUP,   10'd5,    3'd0);
    send_command(OP_LOOKUP,   10'd7,    3'd0);
    send_command(OP_LOOKUP,   10'd5,    3'd0);  // hit
    send_command(OP_MARK,     10'd0,    3'd0);
    send_command(OP_MARK,     10'd0,    3'd4);  // empty slot marked: ignored
    send_command(OP_LOOKUP,   10'd9,    3'd0);
    send_command(OP_LOOKUP,   10'd11,   3'd0);  // all five slots live now
    send_command(OP_MARK,     10'd0,    3'd2);
    send_command(OP_LOOKUP,   10'd3,    3'd0);  // miss with a live victim
    send_command(OP_LOOKUP,   10'd4,    3'd0);
    send_command(OP_INSERT,   10'd0,    3'd0);  // insert of the header
    send_command(OP_INSERT,   10'd6,    3'd0);  // renumber the blocks above it, then miss
    send_command(OP_FLUSH,    10'd0,    3'd2);
    send_command(OP_MARK,     10'd0,    3'd5);  // bad slot index, each opcode
    send_command(OP_DELETE,   10'd0,    3'd6);
    send_command(OP_FORGET,   10'd0,    3'd7);
    send_command(OP_FLUSH,    10'd0,    3'd7);
    send_command(OP_RESERVED, 10'd1023, 3'd1);  // undefined opcode
    send_command(OP_RESERVED, 10'd0,    3'd7);
    send_command(OP_DELETE,   10'd0,    3'd1);
    send_command(OP_DELETE,   10'd0,    3'd1);  // now empty: ignored
    send_command(OP_FORGET,   10'd0,    3'd3);
    send_command(OP_CLEAR,    10'd0,    3'd7);  // bad index: nothing cleared
    send_command(OP_CLEAR,    10'd0,    3'd3);
    send_command(OP_LOOKUP,   10'd8,    3'd0);  // after clear, recency kept

    // Random beats in three phases: light idling, heavy idling, none.
    idle_pct = 14;
    repeat (RANDOM_BEATS) send_random_command();
    idle_pct = 66;
    repeat (RANDOM_BEATS) send_random_command();
    idle_pct = 0;
    repeat (RANDOM_BEATS) send_random_command();
    start <= 1'b0;

    // wait for the last replies; the watchdog bounds this
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("PASS block_buffer_cache_policy");
    end else begin
      $display("FAIL block_buffer_cache_policy");
    end
    $finish;
  end

endmodule
